### rtl/mbt_pkg.sv
// shared constants, codes and types of the multiset bag table
package mbt_pkg;

    localparam int CAPACITY   = 64;
    localparam int ITEM_WIDTH = 32;
    localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int VALUE_W    = 32;
    localparam int CMD_W      = 2;
    localparam int OUT_W      = 7;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE_RD,
        S_MOVE_WR,
        S_REPLY
    } state_t;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [ITEM_WIDTH-1:0] wdata;
        logic [ADDR_W-1:0]     raddr;
    } mem_req_t;

    typedef struct packed {
        logic              clear;
        logic              check;
        logic [ADDR_W-1:0] idx;
    } match_ctl_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OUT_W-1:0]    fill_count;
        logic [OUT_W-1:0]    occurrences;
    } result_t;

endpackage

### rtl/mbt_store.sv
// entry memory: one write port, one registered read port
module mbt_store
    import mbt_pkg::*;
(
    input  logic                  clk,
    input  mem_req_t              req,
    output logic [ITEM_WIDTH-1:0] rdata
);

    logic [ITEM_WIDTH-1:0] mem [CAPACITY];
    logic [ITEM_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/mbt_match.sv
// shared compare unit: counts matches and keeps the first matching index
module mbt_match
    import mbt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  match_ctl_t            ctl,
    input  logic [ITEM_WIDTH-1:0] rdata,
    input  logic [ITEM_WIDTH-1:0] key,
    output logic [CNT_W-1:0]      count,
    output logic                  found,
    output logic [ADDR_W-1:0]     first_idx
);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              found_reg, found_next;
    logic [ADDR_W-1:0] first_reg, first_next;
    logic              hit;

    assign hit = ctl.check && (rdata == key);

    always_comb
    begin
        count_next = count_reg;
        found_next = found_reg;
        first_next = first_reg;
        if (ctl.clear)
        begin
            count_next = '0;
            found_next = 1'b0;
        end
        else if (hit)
        begin
            count_next = count_reg + 1'b1;
            found_next = 1'b1;
            if (!found_reg)
            begin
                first_next = ctl.idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
    end

    assign count     = count_reg;
    assign found     = found_reg;
    assign first_idx = first_reg;

endmodule

### rtl/mbt_ctrl.sv
// sequencer: scans held entries, appends on insert, moves the last entry on remove, builds the result
module mbt_ctrl
    import mbt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CMD_W-1:0]      in_cmd,
    input  logic [VALUE_W-1:0]    in_value,
    input  logic                  out_free,
    output logic                  res_load,
    output result_t               res,
    output mem_req_t              mem_req,
    input  logic [ITEM_WIDTH-1:0] mem_rdata,
    output match_ctl_t            match_ctl,
    output logic [ITEM_WIDTH-1:0] key,
    input  logic [CNT_W-1:0]      match_count,
    input  logic                  match_found,
    input  logic [ADDR_W-1:0]     match_first
);

    state_t                state_reg, state_next;
    logic [CMD_W-1:0]      cmd_reg;
    logic [ITEM_WIDTH-1:0] key_reg;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      held_reg, held_next;
    logic                  check_reg, check_next;
    logic [ADDR_W-1:0]     pidx_reg, pidx_next;
    logic [CNT_W-1:0]      last_w;
    logic [CNT_W-1:0]      occ_w;
    logic                  room;

    assign last_w = held_reg - 1'b1;
    assign room   = held_reg < CNT_W'(CAPACITY);
    assign key    = key_reg;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        held_next       = held_reg;
        check_next      = 1'b0;
        pidx_next       = pidx_reg;
        in_ready        = 1'b0;
        res_load        = 1'b0;
        occ_w           = match_count;
        res.status      = ST_DONE;
        mem_req.we      = 1'b0;
        mem_req.waddr   = held_reg[ADDR_W-1:0];
        mem_req.wdata   = key_reg;
        mem_req.raddr   = idx_reg[ADDR_W-1:0];
        match_ctl.clear = 1'b0;
        match_ctl.check = check_reg;
        match_ctl.idx   = pidx_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    match_ctl.clear = 1'b1;
                    idx_next        = '0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (idx_reg < held_reg)
                begin
                    check_next = 1'b1;
                    pidx_next  = idx_reg[ADDR_W-1:0];
                    idx_next   = idx_reg + 1'b1;
                end
                else if (!check_reg)
                begin
                    if (cmd_reg == CMD_REMOVE && match_found)
                    begin
                        state_next = S_MOVE_RD;
                    end
                    else
                    begin
                        state_next = S_REPLY;
                    end
                end
            end
            S_MOVE_RD:
            begin
                mem_req.raddr = last_w[ADDR_W-1:0];
                state_next    = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = match_first;
                mem_req.wdata = mem_rdata;
                held_next     = last_w;
                state_next    = S_REPLY;
            end
            S_REPLY:
            begin
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (room)
                        begin
                            occ_w = match_count + 1'b1;
                        end
                        else
                        begin
                            res.status = ST_FULL;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (match_found)
                        begin
                            occ_w = match_count - 1'b1;
                        end
                        else
                        begin
                            res.status = ST_NOMATCH;
                        end
                    end
                    default:
                    begin
                        occ_w = match_count;
                    end
                endcase
                if (out_free)
                begin
                    res_load = 1'b1;
                    if (cmd_reg == CMD_INSERT && room)
                    begin
                        mem_req.we = 1'b1;
                        held_next  = held_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        res.occurrences = OUT_W'(occ_w);
        res.fill_count  = OUT_W'(held_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            held_reg  <= '0;
            check_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            held_reg  <= held_next;
            check_reg <= check_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg <= pidx_next;
        if (state_reg == S_IDLE && in_valid)
        begin
            cmd_reg <= in_cmd;
            key_reg <= in_value[ITEM_WIDTH-1:0];
        end
    end

    // fill count never passes the capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // the scan pointer never runs past the held entries
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> idx_reg <= held_reg)
        else $error("scan index past fill count");

    // held count only changes on a remove move or an insert reply
    assert property (@(posedge clk) disable iff (!rst_n)
        held_reg != $past(held_reg) |->
            ($past(state_reg) == S_MOVE_WR || $past(state_reg) == S_REPLY))
        else $error("fill count changed outside an update");

    // a remove move shrinks the table by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MOVE_WR |=> held_reg == CNT_W'($past(held_reg) - 1'b1))
        else $error("remove did not shrink fill count by one");

    // matches counted never exceed the entries scanned
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_REPLY && cmd_reg != CMD_REMOVE |-> match_count <= held_reg)
        else $error("match count above fill count");

endmodule

### rtl/multiset_bag_table_top.sv
// top level of the multiset bag table with stream ports
//
// usage: a fixed-capacity bag of CAPACITY values kept unordered with a fill count.
// input channel s_axis carries one command item: insert, remove one copy, or count
// (the unused command code behaves as count). output channel m_axis returns one
// result item per command: occurrences of the value after the operation, the fill
// count after the operation, and a status (done, insert dropped because full,
// remove found no match).
// each command visits the held entries one per cycle through the single memory read
// port and the shared compare unit; a remove that hits then moves the last entry
// into its slot. the result item shows in the same cycle as the sequencer is ready
// again.
// s_axis_tready is high only while the sequencer is idle, so one item is worked
// on at a time.
// results sit in an output register; a stalled receiver holds m_axis steady and
// the next command is still taken, finishing once the register is free.
// reset clears the fill count and control state; the entry memory is not
// cleared, since only entries below the fill count are ever read.
module multiset_bag_table_top
    import mbt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // command[1:0], value[33:2], zero pad
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata    // occurrences[6:0], fill_count[13:7],
                                                  // status[15:14]
);

    mem_req_t              mem_req;
    logic [ITEM_WIDTH-1:0] mem_rdata;
    match_ctl_t            match_ctl;
    logic [ITEM_WIDTH-1:0] key;
    logic [CNT_W-1:0]      match_count;
    logic                  match_found;
    logic [ADDR_W-1:0]     match_first;
    logic                  out_free;
    logic                  res_load;
    result_t               res;

    logic                  m_valid_reg, m_valid_next;
    result_t               m_data_reg;

    // output register is free when empty or being taken this cycle
    assign out_free = !m_valid_reg || m_axis_tready;

    mbt_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    mbt_match u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (match_ctl),
        .rdata     (mem_rdata),
        .key       (key),
        .count     (match_count),
        .found     (match_found),
        .first_idx (match_first)
    );

    mbt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_cmd      (s_axis_tdata[CMD_W-1:0]),
        .in_value    (s_axis_tdata[CMD_W+VALUE_W-1:CMD_W]),
        .out_free    (out_free),
        .res_load    (res_load),
        .res         (res),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata),
        .match_ctl   (match_ctl),
        .key         (key),
        .match_count (match_count),
        .match_found (match_found),
        .match_first (match_first)
    );

    // output valid: set on load, dropped once the receiver takes the item
    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (res_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            m_data_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_data_reg.status, m_data_reg.fill_count, m_data_reg.occurrences};

endmodule
